// ----- sv/igr_pkg.sv -----
// Package for the irregular-to-grid resampler.
// Holds shared constants, register codes and the structs passed between modules.
`timescale 1ns / 1ps
package igr_pkg;

    localparam int GRID_MAX_DEF  = 4096;
    localparam int MAX_RUN_DEF   = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int APB_AW        = 4;
    localparam int IDX_OUT_W     = 12;
    localparam int DEN_W         = 33;
    localparam int MUL_W         = 34;

    typedef enum logic [1:0] {
        REG_GRID_START = 2'd0,
        REG_GRID_STEP  = 2'd1,
        REG_GRID_COUNT = 2'd2
    } t_reg;

    typedef enum logic {
        KIND_CLEAR,
        KIND_SAMPLE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] pos;
        logic signed [31:0] val;
        logic               last;
    } t_item;

    typedef struct packed {
        logic signed [31:0] start;
        logic        [30:0] step;
        logic        [12:0] count;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_rsp;

endpackage

// ----- sv/igr_if.sv -----
// Stream interfaces for sample input and grid result output.
// Depends on nothing.
`timescale 1ns / 1ps
interface igr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_position;
    logic signed [31:0] sample_value;
    logic               sample_valid;
    logic               last_of_series;

    modport source(output valid, sample_position, sample_value, sample_valid, last_of_series,
                   input ready);
    modport sink(input valid, sample_position, sample_value, sample_valid, last_of_series,
                 output ready);
endinterface

interface igr_out_if;
    logic               valid;
    logic               ready;
    logic        [11:0] grid_index;
    logic signed [31:0] grid_value;
    logic               run_last;
    logic               run_cut;

    modport source(output valid, grid_index, grid_value, run_last, run_cut, input ready);
    modport sink(input valid, grid_index, grid_value, run_last, run_cut, output ready);
endinterface

// ----- sv/igr_front.sv -----
// Front end: accepts samples, drops ones with no effect, queues the rest.
// Depends on igr_pkg and igr_in_if.
`timescale 1ns / 1ps
module igr_front import igr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    igr_in_if.sink s_in,
    input  logic  i_pop,
    output logic  o_avail,
    output t_item o_item
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      n_item;

    assign s_in.ready = (r_cnt != 2'd2);
    assign push       = s_in.valid && s_in.ready && (s_in.sample_valid || s_in.last_of_series);
    assign o_avail    = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_comb begin
        n_item.kind = s_in.sample_valid ? KIND_SAMPLE : KIND_CLEAR;
        n_item.pos  = s_in.sample_position;
        n_item.val  = s_in.sample_value;
        n_item.last = s_in.last_of_series;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

endmodule

// ----- sv/igr_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on igr_pkg.
`timescale 1ns / 1ps
module igr_div import igr_pkg::*; #(
    parameter int NUM_W = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quot,
    output t_div_rsp         o_rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   sub;
    logic             ge;

    assign sh  = {r_rem, r_num[NUM_W-1]};
    assign sub = sh - {1'b0, r_den};
    assign ge  = (sh >= {1'b0, r_den});

    assign o_quot       = r_num;
    assign o_rsp.done   = r_done;
    assign o_rsp.rem_nz = |r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? sub[DEN_W-1:0] : sh[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- sv/igr_back.sv -----
// Back end: segment sequencer with slope and index division, shift-add
// multiply, per-point accumulation and the result register. Uses igr_pkg, igr_out_if.
`timescale 1ns / 1ps
module igr_back import igr_pkg::*; #(
    parameter int GRID_MAX  = GRID_MAX_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_avail,
    input  t_item                  i_item,
    output logic                   o_pop,
    output logic                   o_div_start,
    output logic [32+FRAC_BITS:0]  o_div_num,
    output logic [DEN_W-1:0]       o_div_den,
    input  logic [32+FRAC_BITS:0]  i_div_quot,
    input  t_div_rsp               i_div_rsp,
    igr_out_if.source              m_out
);

    localparam int NUM_W   = 33 + FRAC_BITS;
    localparam int SLOPE_W = NUM_W + 1;
    localparam int ACC_W   = FRAC_BITS + 75;
    localparam int IDX_W   = $clog2(GRID_MAX + 1);
    localparam int CW      = (IDX_W > 13) ? IDX_W : 13;
    localparam int X_W     = IDX_W + 40;
    localparam int KW      = IDX_W + 8;
    localparam int N_W     = $clog2(MAX_RUN + 1);
    localparam int MC_W    = $clog2(MUL_W + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DSLOPE, S_DK, S_XK, S_CHECK, S_MINC, S_MDX, S_EMIT
    } t_state;

    localparam logic signed [ACC_W-1:0] P_MAX = {{(ACC_W-63){1'b0}}, {63{1'b1}}};
    localparam logic signed [ACC_W-1:0] N_MAX = -P_MAX;
    localparam logic signed [ACC_W-1:0] V_MAX = ACC_W'(64'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] V_MIN = -V_MAX - ACC_W'(1);

    t_state                    r_state;
    logic                      r_have;
    logic signed [31:0]        r_ppos;
    logic signed [31:0]        r_pval;
    logic        [IDX_W-1:0]   r_ngp;
    logic signed [31:0]        r_pos;
    logic signed [31:0]        r_val;
    logic                      r_last;
    logic                      r_dneg;
    logic signed [SLOPE_W-1:0] r_slope;
    logic        [IDX_W-1:0]   r_k;
    logic signed [X_W-1:0]     r_x;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   r_inc;
    logic signed [ACC_W-1:0]   r_mcand;
    logic        [MUL_W-1:0]   r_mplier;
    logic        [MUL_W-1:0]   r_dxmag;
    logic                      r_dxneg;
    logic        [MC_W-1:0]    r_mcnt;
    logic        [N_W-1:0]     r_n;
    logic                      r_cut;
    logic                      r_dstart;
    logic        [NUM_W-1:0]   r_dnum;
    logic        [DEN_W-1:0]   r_dden;
    logic                      r_ov;
    logic        [11:0]        r_oidx;
    logic signed [31:0]        r_oval;
    logic                      r_olast;
    logic                      r_ocut;

    logic        [30:0]        step_e;
    logic        [CW-1:0]      cnt_w;
    logic        [IDX_W-1:0]   count;
    logic signed [31:0]        gstart;
    logic signed [32:0]        dv;
    logic        [32:0]        dvmag;
    logic signed [32:0]        dp;
    logic signed [32:0]        off;
    logic signed [SLOPE_W-1:0] slope_n;
    logic        [NUM_W-1:0]   kmax;
    logic        [IDX_W+30:0]  kx;
    logic signed [X_W-1:0]     pos_x;
    logic signed [X_W-1:0]     dx0;
    logic        [37:0]        run_step;
    logic                      q0;
    logic                      cut_n;
    logic signed [ACC_W-1:0]   acc_nx;
    logic                      lst;
    logic                      ovf;
    logic signed [ACC_W-1:0]   vsum;
    logic signed [31:0]        vout;
    logic                      out_free;
    logic                      start_seg;
    logic                      start_idx;

    assign gstart = i_cfg.start;
    assign step_e = (i_cfg.step == 31'd0) ? 31'd1 : i_cfg.step;
    assign cnt_w  = (CW'(i_cfg.count) < CW'(GRID_MAX)) ? CW'(i_cfg.count) : CW'(GRID_MAX);
    assign count  = IDX_W'(cnt_w);

    assign o_pop       = (r_state == S_IDLE) && i_avail;
    assign o_div_start = r_dstart;
    assign o_div_num   = r_dnum;
    assign o_div_den   = r_dden;

    assign m_out.valid      = r_ov;
    assign m_out.grid_index = r_oidx;
    assign m_out.grid_value = r_oval;
    assign m_out.run_last   = r_olast;
    assign m_out.run_cut    = r_ocut;

    always_comb begin
        dv       = 33'(i_item.val) - 33'(r_pval);
        dvmag    = dv[32] ? 33'(-dv) : 33'(dv);
        dp       = 33'(i_item.pos) - 33'(r_ppos);
        off      = 33'(r_ppos) - 33'(gstart);
        slope_n  = r_dneg ? -(SLOPE_W'(i_div_quot) + SLOPE_W'(i_div_rsp.rem_nz))
                          : SLOPE_W'(i_div_quot);
        kmax     = (i_div_quot > NUM_W'(r_ngp)) ? i_div_quot : NUM_W'(r_ngp);
        kx       = (IDX_W+31)'(r_k) * (IDX_W+31)'(step_e);
        pos_x    = X_W'(r_pos);
        dx0      = r_x - X_W'(r_ppos);
        run_step = 38'(step_e) * 38'(MAX_RUN);
        q0       = (r_k < count) && (r_x <= pos_x);
        cut_n    = ((KW'(r_k) + KW'(MAX_RUN)) < KW'(count))
                   && ((r_x + $signed(X_W'(run_step))) <= pos_x);
        acc_nx   = r_mplier[0] ? r_acc + r_mcand : r_acc;
        lst      = (r_n == N_W'(MAX_RUN - 1)) || ((KW'(r_k) + KW'(1)) >= KW'(count))
                   || ((r_x + $signed(X_W'(step_e))) > pos_x);
        ovf      = (r_acc > P_MAX) || (r_acc < N_MAX);
        vsum     = (r_acc >>> FRAC_BITS) + ACC_W'(r_pval);
        if (ovf) begin
            vout = r_acc[ACC_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (vsum > V_MAX) begin
            vout = 32'sh7FFFFFFF;
        end else if (vsum < V_MIN) begin
            vout = 32'sh80000000;
        end else begin
            vout = vsum[31:0];
        end
        out_free  = !r_ov || m_out.ready;
        start_seg = (r_state == S_IDLE) && i_avail && (i_item.kind == KIND_SAMPLE)
                    && r_have && (i_item.pos > r_ppos);
        start_idx = (r_state == S_DSLOPE) && i_div_rsp.done && !off[32]
                    && (off != 33'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= start_seg || start_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_have   <= 1'b0;
            r_ppos   <= '0;
            r_pval   <= '0;
            r_ngp    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && m_out.ready && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_pos  <= i_item.pos;
                        r_val  <= i_item.val;
                        r_last <= i_item.last;
                        if (i_item.kind == KIND_CLEAR) begin
                            r_have <= 1'b0;
                            r_ppos <= '0;
                            r_pval <= '0;
                            r_ngp  <= '0;
                        end else if (r_have && (i_item.pos > r_ppos)) begin
                            r_dneg   <= dv[32];
                            r_dnum   <= NUM_W'(dvmag) << FRAC_BITS;
                            r_dden   <= DEN_W'(dp);
                            r_state  <= S_DSLOPE;
                        end else if (i_item.last) begin
                            r_have <= 1'b0;
                            r_ppos <= '0;
                            r_pval <= '0;
                            r_ngp  <= '0;
                        end else begin
                            r_have <= 1'b1;
                            r_ppos <= i_item.pos;
                            r_pval <= i_item.val;
                        end
                    end
                end
                S_DSLOPE: begin
                    if (i_div_rsp.done) begin
                        r_slope <= slope_n;
                        if (!off[32] && (off != 33'sd0)) begin
                            r_dnum   <= NUM_W'(off[31:0]);
                            r_dden   <= DEN_W'(step_e);
                            r_state  <= S_DK;
                        end else begin
                            r_k     <= r_ngp;
                            r_state <= S_XK;
                        end
                    end
                end
                S_DK: begin
                    if (i_div_rsp.done) begin
                        r_k     <= (kmax < NUM_W'(count)) ? kmax[IDX_W-1:0] : count;
                        r_state <= S_XK;
                    end
                end
                S_XK: begin
                    r_x     <= X_W'(gstart) + $signed(X_W'(kx));
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (!q0) begin
                        if (r_last) begin
                            r_have <= 1'b0;
                            r_ppos <= '0;
                            r_pval <= '0;
                            r_ngp  <= '0;
                        end else begin
                            r_have <= 1'b1;
                            r_ppos <= r_pos;
                            r_pval <= r_val;
                            r_ngp  <= r_k;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_cut    <= cut_n;
                        r_dxneg  <= dx0[X_W-1];
                        r_dxmag  <= dx0[X_W-1] ? MUL_W'(-dx0) : MUL_W'(dx0);
                        r_mcand  <= ACC_W'(r_slope);
                        r_mplier <= MUL_W'(step_e);
                        r_acc    <= '0;
                        r_mcnt   <= '0;
                        r_state  <= S_MINC;
                    end
                end
                S_MINC: begin
                    if (r_mcnt == MC_W'(MUL_W - 1)) begin
                        r_inc    <= acc_nx;
                        r_acc    <= '0;
                        r_mcand  <= ACC_W'(r_slope);
                        r_mplier <= r_dxmag;
                        r_mcnt   <= '0;
                        r_state  <= S_MDX;
                    end else begin
                        r_mcand  <= r_mcand <<< 1;
                        r_mplier <= r_mplier >> 1;
                        r_acc    <= acc_nx;
                        r_mcnt   <= r_mcnt + MC_W'(1);
                    end
                end
                S_MDX: begin
                    if (r_mcnt == MC_W'(MUL_W - 1)) begin
                        r_acc   <= r_dxneg ? -acc_nx : acc_nx;
                        r_n     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_mcand  <= r_mcand <<< 1;
                        r_mplier <= r_mplier >> 1;
                        r_acc    <= acc_nx;
                        r_mcnt   <= r_mcnt + MC_W'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_oidx  <= IDX_OUT_W'(r_k);
                        r_oval  <= vout;
                        r_olast <= lst;
                        r_ocut  <= r_cut;
                        r_acc   <= r_acc + r_inc;
                        r_x     <= r_x + $signed(X_W'(step_e));
                        r_k     <= r_k + IDX_W'(1);
                        r_n     <= r_n + N_W'(1);
                        if (lst) begin
                            if (r_last) begin
                                r_have <= 1'b0;
                                r_ppos <= '0;
                                r_pval <= '0;
                                r_ngp  <= '0;
                            end else begin
                                r_have <= 1'b1;
                                r_ppos <= r_pos;
                                r_pval <= r_val;
                                r_ngp  <= r_k + IDX_W'(1);
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/irregular_to_grid_linear_resampler_top.sv -----
// Top level: APB register block, front queue, shared divider and back-end sequencer.
// A segment runs the slope division, then the start-index division when the stored sample
// lies past grid_start, then the shift-add products, then emits one grid point per cycle
// while the output is free. A segment with no grid point still pays the divisions.
// Synchronous reset, active low; clears series state, queue and registers.
`timescale 1ns / 1ps
module irregular_to_grid_linear_resampler_top import igr_pkg::*; #(
    parameter int GRID_MAX  = GRID_MAX_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    igr_in_if.sink            i_sample,
    igr_out_if.source         o_grid,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready
);

    localparam int NUM_W = 33 + FRAC_BITS;

    logic signed [31:0] r_grid_start;
    logic        [30:0] r_grid_step;
    logic        [12:0] r_grid_count;
    t_cfg               cfg;
    t_reg               reg_idx;
    logic               wr;
    logic               q_avail;
    logic               q_pop;
    t_item              q_item;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [NUM_W-1:0]   div_quot;
    t_div_rsp           div_rsp;

    assign o_pready = 1'b1;
    assign reg_idx  = t_reg'(i_paddr[3:2]);
    assign wr       = i_psel && i_penable && i_pwrite;

    assign cfg.start = r_grid_start;
    assign cfg.step  = r_grid_step;
    assign cfg.count = r_grid_count;

    always_comb begin
        unique case (reg_idx)
            REG_GRID_START: o_prdata = r_grid_start;
            REG_GRID_STEP:  o_prdata = {1'b0, r_grid_step};
            REG_GRID_COUNT: o_prdata = {19'd0, r_grid_count};
            default:        o_prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_start <= '0;
            r_grid_step  <= 31'd65536;
            r_grid_count <= 13'd4096;
        end else if (wr) begin
            unique case (reg_idx)
                REG_GRID_START: r_grid_start <= i_pwdata;
                REG_GRID_STEP:  r_grid_step  <= i_pwdata[30:0];
                REG_GRID_COUNT: r_grid_count <= i_pwdata[12:0];
                default: ;
            endcase
        end
    end

    igr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (i_sample),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    igr_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_rsp   (div_rsp)
    );

    igr_back #(
        .GRID_MAX  (GRID_MAX),
        .MAX_RUN   (MAX_RUN),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_avail     (q_avail),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_div_start (div_start),
        .o_div_num   (div_num),
        .o_div_den   (div_den),
        .i_div_quot  (div_quot),
        .i_div_rsp   (div_rsp),
        .m_out       (o_grid)
    );

    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_avail)
        else $error("queue popped while empty");

    a_div_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !div_rsp.done)
        else $error("divider finished right after start");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_grid.valid)
        else $error("result valid after reset");

endmodule

// ----- verif/irregular_to_grid_linear_resampler_top_test.sv -----
// Self-checking testbench for the irregular-to-grid linear resampler top level.
// Drives sample transactions, writes the grid registers over APB and checks every grid
// point against an internal predictor; depends on igr_pkg, igr_if and the RTL.
`timescale 1ns / 1ps
module irregular_to_grid_linear_resampler_top_test;
    import igr_pkg::*;

    localparam int  WATCHDOG_LIMIT = 50000;
    localparam int  SETTLE_CYCLES  = 300;
    localparam int  HOLD_CYCLES    = 400;
    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;

    typedef struct {
        logic [11:0]        idx;
        logic signed [31:0] val;
        logic               last;
        logic               cut;
    } grid_point_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_psel = 1'b0, i_penable = 1'b0, i_pwrite = 1'b0;
    logic [APB_AW-1:0] i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic o_pready;

    igr_in_if  smp();
    igr_out_if grd();

    irregular_to_grid_linear_resampler_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(smp), .o_grid(grd),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite), .i_paddr(i_paddr),
        .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and register copy
    logic signed [31:0] grid_start_q = 32'sd0;
    logic [30:0]        grid_step_q  = 31'd65536;
    logic [12:0]        grid_count_q = 13'd4096;
    bit     have_prev = 0;
    longint prev_pos = 0, prev_val = 0, next_point = 0;

    grid_point_t expected_points[$];
    int  err_count = 0;
    int  max_gap = 12;
    bit  rx_quiet = 0;
    bit  hold_req = 0;
    int  idle_cycles = 0;

    initial begin
        smp.valid = 1'b0;
        smp.sample_position = '0;
        smp.sample_value = '0;
        smp.sample_valid = 1'b0;
        smp.last_of_series = 1'b0;
        grd.ready = 1'b0;
    end

    function automatic longint floor_div(longint n, longint d);
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > SAT_MAX) return 32'sh7FFFFFFF;
        if (v < SAT_MIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] interpolate(longint slope, longint dx, longint v0);
        longint unsigned ms, md;
        bit neg;
        longint prod;
        ms = slope < 0 ? -slope : slope;
        md = dx < 0 ? -dx : dx;
        neg = (slope < 0) != (dx < 0);
        if (ms == 0 || md == 0) return sat32(v0);
        if (ms > 64'h7FFFFFFFFFFFFFFF / md) return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        prod = ms * md;
        if (neg) prod = -prod;
        return sat32(v0 + (prod >>> FRAC_BITS_DEF));
    endfunction

    function automatic void predict_grid_points(logic signed [31:0] pos_in,
                                                logic signed [31:0] val_in,
                                                logic vld, logic lst);
        longint p, v, st, stp, cnt, slope, off, k;
        int n;
        bit cut;
        grid_point_t pts[$];
        grid_point_t pt;
        p = pos_in;
        v = val_in;
        st = grid_start_q;
        n = 0;
        if (vld) begin
            if (have_prev && p > prev_pos) begin
                stp = grid_step_q == 0 ? 1 : grid_step_q;
                cnt = grid_count_q < GRID_MAX_DEF ? grid_count_q : GRID_MAX_DEF;
                slope = floor_div((v - prev_val) * (64'sd1 << FRAC_BITS_DEF), p - prev_pos);
                off = prev_pos - st;
                k = off > 0 ? off / stp : 0;
                if (k < next_point) k = next_point;
                while (n < MAX_RUN_DEF && k < cnt && st + k * stp <= p) begin
                    pt.idx  = k[11:0];
                    pt.val  = interpolate(slope, st + k * stp - prev_pos, prev_val);
                    pt.last = 1'b0;
                    pt.cut  = 1'b0;
                    pts.push_back(pt);
                    n++;
                    k++;
                end
                cut = k < cnt && st + k * stp <= p;
                foreach (pts[i]) begin
                    pts[i].cut  = cut;
                    pts[i].last = (i == n - 1);
                    expected_points.push_back(pts[i]);
                end
                next_point = k < cnt ? k : cnt;
            end
            have_prev = 1;
            prev_pos = p;
            prev_val = v;
        end
        if (lst) begin
            have_prev = 0;
            prev_pos = 0;
            prev_val = 0;
            next_point = 0;
        end
    endfunction

    task automatic report_mismatch(string what, longint exp_v, longint got_v);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && grd.valid && grd.ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result, index", -1, grd.grid_index);
            end else begin
                if (grd.grid_index !== expected_points[0].idx)
                    report_mismatch("grid_index", expected_points[0].idx, grd.grid_index);
                if (grd.grid_value !== expected_points[0].val)
                    report_mismatch("grid_value", expected_points[0].val, grd.grid_value);
                if (grd.run_last !== expected_points[0].last)
                    report_mismatch("run_last", expected_points[0].last, grd.run_last);
                if (grd.run_cut !== expected_points[0].cut)
                    report_mismatch("run_cut", expected_points[0].cut, grd.run_cut);
                void'(expected_points.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (grd.valid && grd.ready) || i_psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** irregular_to_grid_linear_resampler_top: FAILED **");
            $finish;
        end
    end

    // receiver
    initial begin : receiver
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 12);
            if (hold_req) begin
                hold_req = 0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                grd.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            grd.ready <= 1'b1;
            do @(posedge i_clk); while (!(grd.valid && grd.ready));
            @(negedge i_clk);
        end
    end

    task automatic send_sample(logic signed [31:0] pos, logic signed [31:0] val,
                               logic vld, logic lst);
        int gap;
        gap = $urandom_range(0, max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp.sample_position <= pos;
        smp.sample_value    <= val;
        smp.sample_valid    <= vld;
        smp.last_of_series  <= lst;
        smp.valid           <= 1'b1;
        do @(posedge i_clk); while (!(smp.valid && smp.ready));
        predict_grid_points(pos, val, vld, lst);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        smp.valid <= 1'b0;
        while (expected_points.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] data);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_pwrite  <= 1'b1;
        i_penable <= 1'b0;
        i_paddr   <= APB_AW'(4 * idx);
        i_pwdata  <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        case (idx)
            REG_GRID_START: grid_start_q = data;
            REG_GRID_STEP:  grid_step_q  = data[30:0];
            REG_GRID_COUNT: grid_count_q = data[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic set_grid(logic [31:0] start, logic [31:0] step, logic [31:0] count);
        wait_idle();
        write_reg(REG_GRID_START, start);
        write_reg(REG_GRID_STEP, step);
        write_reg(REG_GRID_COUNT, count);
    endtask

    function automatic logic signed [31:0] clamp32(longint v);
        return sat32(v);
    endfunction

    task automatic run_random_series(int n_items);
        longint cur, st, stp;
        int r, left;
        logic lst;
        st = grid_start_q;
        stp = grid_step_q == 0 ? 1 : grid_step_q;
        if (stp > 64'sd1 << 30) stp = 64'sd1 << 30;
        left = 0;
        cur = 0;
        repeat (n_items) begin
            if (left == 0) begin
                left = $urandom_range(2, 10);
                cur = st + longint'($urandom_range(0, 20)) * stp - 4 * stp;
            end
            left--;
            lst = (left == 0);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_sample($urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (r < 15) begin
                send_sample($urandom, $urandom, 1'b0, lst);
            end else if (r < 22) begin
                send_sample(clamp32(cur - $urandom_range(0, 1000)), $urandom, 1'b1, lst);
            end else begin
                if (r >= 97)
                    cur += stp * $urandom_range(60, 90);
                else
                    cur += stp * $urandom_range(0, 3) + $urandom_range(1, stp);
                cur = clamp32(cur);
                send_sample(cur, $urandom, 1'b1, lst);
            end
        end
        send_sample(0, 0, 1'b0, 1'b1);
    endtask

    task automatic test_directed();
        send_sample(32'sd5 << 16, 32'sd100, 1'b0, 1'b0);
        send_sample(32'sd0, 32'sd0, 1'b1, 1'b0);
        send_sample(32'sd3 << 16, 32'sh00030000, 1'b1, 1'b0);
        send_sample(32'sd2 << 16, 32'sd7, 1'b1, 1'b0);
        send_sample(32'sd2 << 16, 32'sh7FFFFFFF, 1'b1, 1'b0);
        send_sample(32'sd9 << 16, 32'sh80000000, 1'b1, 1'b0);
        send_sample(32'sd100 << 16, 32'sh7FFFFFFF, 1'b1, 1'b1);
        send_sample(32'sd1 << 16, -32'sd5, 1'b1, 1'b0);
        send_sample(32'sd4 << 16, 32'sd5, 1'b1, 1'b1);
        send_sample(32'sh80000000, 32'sh80000000, 1'b1, 1'b0);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 1'b1);
        // large step, steep slope: output saturation
        set_grid(32'h80000000, 32'h7FFFFFFF, 32'd4096);
        send_sample(32'sh7FFFFFFD, 32'sh80000000, 1'b1, 1'b0);
        send_sample(32'sh7FFFFFFE, 32'sh7FFFFFFF, 1'b1, 1'b1);
        // zero count and zero step
        set_grid(32'h0, 32'h0, 32'h0);
        send_sample(32'sd0, 32'sd0, 1'b1, 1'b0);
        send_sample(32'sd50, 32'sd1000, 1'b1, 1'b1);
        set_grid(32'h0, 32'h0, 32'd1);
        send_sample(32'sd0, 32'sd0, 1'b1, 1'b0);
        send_sample(32'sd50, 32'sd1000, 1'b1, 1'b1);
        set_grid(32'hFFFFFFFF, 32'h00010000, 32'h1FFF);
        send_sample(32'sd4095 << 16, 32'sd1, 1'b1, 1'b0);
        send_sample(32'sh7FFFFFFF, 32'sd2, 1'b1, 1'b1);
    endtask

    task automatic test_random_grids();
        set_grid(32'h0, 32'h00010000, 32'd4096);
        run_random_series(70);
        set_grid(-($urandom_range(1, 40) << 16), $urandom_range(1 << 12, 1 << 18),
                 $urandom_range(1, 200));
        run_random_series(70);
        set_grid($urandom, 32'd1, 32'd4096);
        run_random_series(60);
        max_gap = 0;
        rx_quiet = 1;
        set_grid(32'h7FFF0000, $urandom_range(1, 1 << 16), 32'd1);
        run_random_series(40);
        set_grid($urandom, 32'h7FFFFFFF, $urandom_range(1, 4096));
        run_random_series(40);
        max_gap = 12;
        rx_quiet = 0;
    endtask

    task automatic test_backpressure();
        int i;
        set_grid(32'h0, 32'h00010000, 32'd4096);
        max_gap = 0;
        hold_req = 1;
        send_sample(32'sd0, $urandom, 1'b1, 1'b0);
        for (i = 1; i <= 30; i++)
            send_sample(i * (32'sd8 << 16), $urandom, 1'b1, i == 30);
        max_gap = 12;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_grids();
        test_backpressure();
        wait_idle();
        if (err_count == 0 && expected_points.size() == 0) begin
            $display("** irregular_to_grid_linear_resampler_top: PASSED **");
        end else begin
            $display("** irregular_to_grid_linear_resampler_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/igr_pkg.sv
sv/igr_if.sv
sv/igr_front.sv
sv/igr_div.sv
sv/igr_back.sv
sv/irregular_to_grid_linear_resampler_top.sv
verif/irregular_to_grid_linear_resampler_top_test.sv
